// ===== sv/tfn_pkg.sv =====
`timescale 1ns / 1ps
package tfn_pkg;

    localparam int CoordWidth   = 24;
    localparam int NormFracBits = 14;

    localparam int DiffW   = CoordWidth + 1;
    localparam int ProdW   = 2 * DiffW;
    localparam int CrossW  = ProdW + 1;
    localparam int TopW    = $clog2(CrossW);
    localparam int ScaleW  = 31;
    localparam int SqW     = 2 * ScaleW;
    localparam int SumW    = SqW + 2;
    localparam int RootW   = SumW / 2;
    localparam int RemW    = RootW + 4;
    localparam int QuotW   = NormFracBits + 1;
    localparam int DivW    = ScaleW + NormFracBits + 2;
    localparam int ResW    = (NormFracBits + 2 > 16) ? NormFracBits + 2 : 16;
    localparam int OutW    = 16;
    localparam int SlotW   = 2;
    localparam int FrontStages = 7;

    localparam logic [SlotW-1:0] SlotLast = SlotW'(2);

    typedef logic signed [DiffW-1:0]  t_diff;
    typedef logic signed [ProdW-1:0]  t_prod;
    typedef logic signed [CrossW-1:0] t_cross;
    typedef logic [CrossW-1:0]        t_mag;
    typedef logic [SqW-1:0]           t_sq;
    typedef logic [SumW-1:0]          t_sum;
    typedef logic [RemW-1:0]          t_rem;
    typedef logic [DivW-1:0]          t_dvw;
    typedef logic signed [ResW-1:0]   t_res;

    typedef struct packed {
        logic [RemW-1:0]              rem;
        logic [RootW-1:0]             root;
        logic [SumW-1:0]              rad;
        logic [2:0][ScaleW-1:0]       c;
        logic [2:0]                   neg;
        logic                         degen;
    } t_sqrt_stage;

    typedef struct packed {
        logic [2:0][DivW-1:0]         rem;
        logic [2:0][QuotW-1:0]        q;
        logic [RootW-1:0]             len;
        logic [2:0]                   neg;
        logic                         degen;
    } t_div_stage;

    // one digit of the square root: bring down two radicand bits, try root*4+1
    function automatic t_sqrt_stage sqrt_step(t_sqrt_stage s);
        t_sqrt_stage o;
        t_rem        r;
        t_rem        trial;
        o     = s;
        r     = {s.rem[RemW-3:0], s.rad[SumW-1 -: 2]};
        trial = t_rem'({s.root, 2'b01});
        o.rad = {s.rad[SumW-3:0], 2'b00};
        if (r >= trial) begin
            o.rem  = r - trial;
            o.root = {s.root[RootW-2:0], 1'b1};
        end else begin
            o.rem  = r;
            o.root = {s.root[RootW-2:0], 1'b0};
        end
        return o;
    endfunction

    // one quotient bit for each of the three components
    function automatic t_div_stage div_step(t_div_stage s, int bpos);
        t_div_stage o;
        t_dvw       d;
        o = s;
        d = t_dvw'(s.len) << bpos;
        for (int i = 0; i < 3; i++) begin
            if (s.rem[i] >= d) begin
                o.rem[i]    = s.rem[i] - d;
                o.q[i][bpos] = 1'b1;
            end
        end
        return o;
    endfunction

endpackage

// ===== sv/triangle_face_normal.sv =====
`timescale 1ns / 1ps
// Flat face normal of one triangle per input beat (Q8.16 vertices in, Q1.14
// unit normal out). Each triangle produces three output beats carrying the
// same normal with vertex_slot 0, 1, 2; last marks slot 2; a zero cross
// product gives a zero normal with degenerate set. The first output beat
// appears after the triangle has passed 7 front stages (edges, six
// 25x25 products, cross, magnitude, leading-one, scale, squares), one sum
// stage, 32 square-root stages (one root bit each), one divider load stage,
// 15 divider stages (one quotient bit each, three lanes) and the output
// register. A triangle may enter every cycle while o_ready is high; o_ready
// drops when a finished triangle waits for the output register (three beats each).
module triangle_face_normal (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [tfn_pkg::CoordWidth-1:0]   i_v0_x,
    input  logic signed [tfn_pkg::CoordWidth-1:0]   i_v0_y,
    input  logic signed [tfn_pkg::CoordWidth-1:0]   i_v0_z,
    input  logic signed [tfn_pkg::CoordWidth-1:0]   i_v1_x,
    input  logic signed [tfn_pkg::CoordWidth-1:0]   i_v1_y,
    input  logic signed [tfn_pkg::CoordWidth-1:0]   i_v1_z,
    input  logic signed [tfn_pkg::CoordWidth-1:0]   i_v2_x,
    input  logic signed [tfn_pkg::CoordWidth-1:0]   i_v2_y,
    input  logic signed [tfn_pkg::CoordWidth-1:0]   i_v2_z,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [tfn_pkg::OutW-1:0]         o_normal_x,
    output logic signed [tfn_pkg::OutW-1:0]         o_normal_y,
    output logic signed [tfn_pkg::OutW-1:0]         o_normal_z,
    output logic [tfn_pkg::SlotW-1:0]               o_vertex_slot,
    output logic                                    o_last,
    output logic                                    o_degenerate
);

    localparam int SqrtSteps = tfn_pkg::RootW;
    localparam int DivSteps  = tfn_pkg::QuotW;

    logic                                  en;
    logic                                  load;

    logic [tfn_pkg::FrontStages-1:0]       r_vf;
    logic [SqrtSteps:0]                    r_vs;
    logic [DivSteps:0]                     r_vd;

    tfn_pkg::t_diff                        r_a [3];
    tfn_pkg::t_diff                        r_b [3];
    tfn_pkg::t_prod                        r_p [6];
    tfn_pkg::t_cross                       r_n [3];
    tfn_pkg::t_mag                         r_m4 [3];
    logic [2:0]                            r_neg4;
    tfn_pkg::t_mag                         r_m5 [3];
    logic [2:0]                            r_neg5;
    logic [tfn_pkg::TopW-1:0]              r_top5;
    logic                                  r_dg5;
    logic [2:0][tfn_pkg::ScaleW-1:0]       r_c6;
    logic [2:0]                            r_neg6;
    logic                                  r_dg6;
    tfn_pkg::t_sq                          r_sq7 [3];
    logic [2:0][tfn_pkg::ScaleW-1:0]       r_c7;
    logic [2:0]                            r_neg7;
    logic                                  r_dg7;
    tfn_pkg::t_sqrt_stage                  r_rt [SqrtSteps+1];
    tfn_pkg::t_div_stage                   r_dv [DivSteps+1];

    logic [tfn_pkg::TopW-1:0]              n_top;
    logic                                  n_dg;
    tfn_pkg::t_mag                         n_any;
    tfn_pkg::t_mag                         sh;
    logic [2:0][tfn_pkg::ScaleW-1:0]       n_c;
    tfn_pkg::t_sqrt_stage                  n_rt0;
    tfn_pkg::t_div_stage                   n_dv0;
    tfn_pkg::t_res                         res [3];
    logic signed [tfn_pkg::OutW-1:0]       n_out [3];

    logic                                  r_ov;
    logic [tfn_pkg::SlotW-1:0]             r_slot;
    logic signed [tfn_pkg::OutW-1:0]       r_nx, r_ny, r_nz;
    logic                                  r_dg;

    // the output holder reloads when empty or when its last beat leaves
    assign load    = r_vd[DivSteps] && (!r_ov || (i_ready && r_slot == tfn_pkg::SlotLast));
    assign en      = !r_vd[DivSteps] || load;
    assign o_ready = en;

    always_comb begin
        n_any = '0;
        for (int i = 0; i < 3; i++) n_any = n_any | r_m4[i];
        n_top = '0;
        for (int i = 0; i < tfn_pkg::CrossW; i++) begin
            if (n_any[i]) n_top = tfn_pkg::TopW'(i);
        end
        n_dg = (n_any == '0);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_top5 > tfn_pkg::TopW'(tfn_pkg::ScaleW - 1))
                sh = r_m5[i] >> (r_top5 - tfn_pkg::TopW'(tfn_pkg::ScaleW - 1));
            else
                sh = r_m5[i] << (tfn_pkg::TopW'(tfn_pkg::ScaleW - 1) - r_top5);
            n_c[i] = sh[tfn_pkg::ScaleW-1:0];
        end
    end

    always_comb begin
        n_rt0       = '0;
        n_rt0.rad   = tfn_pkg::t_sum'(r_sq7[0]) + tfn_pkg::t_sum'(r_sq7[1])
                    + tfn_pkg::t_sum'(r_sq7[2]);
        n_rt0.c     = r_c7;
        n_rt0.neg   = r_neg7;
        n_rt0.degen = r_dg7;
    end

    always_comb begin
        n_dv0       = '0;
        n_dv0.len   = r_rt[SqrtSteps].root;
        n_dv0.neg   = r_rt[SqrtSteps].neg;
        n_dv0.degen = r_rt[SqrtSteps].degen;
        for (int i = 0; i < 3; i++) begin
            n_dv0.rem[i] = (tfn_pkg::t_dvw'(r_rt[SqrtSteps].c[i]) << tfn_pkg::NormFracBits)
                         + tfn_pkg::t_dvw'(r_rt[SqrtSteps].root >> 1);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            res[i] = tfn_pkg::t_res'(r_dv[DivSteps].q[i]);
            if (r_dv[DivSteps].neg[i]) res[i] = -res[i];
            n_out[i] = r_dv[DivSteps].degen ? '0 : res[i][tfn_pkg::OutW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= '0;
            r_vs <= '0;
            r_vd <= '0;
        end else if (en) begin
            r_vf <= {r_vf[tfn_pkg::FrontStages-2:0], i_valid};
            r_vs <= {r_vs[SqrtSteps-1:0], r_vf[tfn_pkg::FrontStages-1]};
            r_vd <= {r_vd[DivSteps-1:0], r_vs[SqrtSteps]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a[0] <= tfn_pkg::t_diff'(i_v1_x) - tfn_pkg::t_diff'(i_v0_x);
            r_a[1] <= tfn_pkg::t_diff'(i_v1_y) - tfn_pkg::t_diff'(i_v0_y);
            r_a[2] <= tfn_pkg::t_diff'(i_v1_z) - tfn_pkg::t_diff'(i_v0_z);
            r_b[0] <= tfn_pkg::t_diff'(i_v2_x) - tfn_pkg::t_diff'(i_v0_x);
            r_b[1] <= tfn_pkg::t_diff'(i_v2_y) - tfn_pkg::t_diff'(i_v0_y);
            r_b[2] <= tfn_pkg::t_diff'(i_v2_z) - tfn_pkg::t_diff'(i_v0_z);

            r_p[0] <= tfn_pkg::t_prod'(r_a[1]) * tfn_pkg::t_prod'(r_b[2]);
            r_p[1] <= tfn_pkg::t_prod'(r_a[2]) * tfn_pkg::t_prod'(r_b[1]);
            r_p[2] <= tfn_pkg::t_prod'(r_a[2]) * tfn_pkg::t_prod'(r_b[0]);
            r_p[3] <= tfn_pkg::t_prod'(r_a[0]) * tfn_pkg::t_prod'(r_b[2]);
            r_p[4] <= tfn_pkg::t_prod'(r_a[0]) * tfn_pkg::t_prod'(r_b[1]);
            r_p[5] <= tfn_pkg::t_prod'(r_a[1]) * tfn_pkg::t_prod'(r_b[0]);

            for (int i = 0; i < 3; i++) begin
                r_n[i] <= tfn_pkg::t_cross'(r_p[2*i]) - tfn_pkg::t_cross'(r_p[2*i+1]);
                r_neg4[i] <= r_n[i][tfn_pkg::CrossW-1];
                r_m4[i]   <= r_n[i][tfn_pkg::CrossW-1] ? tfn_pkg::t_mag'(-r_n[i])
                                                       : tfn_pkg::t_mag'(r_n[i]);
                r_m5[i]   <= r_m4[i];
                r_sq7[i]  <= tfn_pkg::t_sq'(r_c6[i]) * tfn_pkg::t_sq'(r_c6[i]);
            end
            r_neg5 <= r_neg4;
            r_top5 <= n_top;
            r_dg5  <= n_dg;

            r_c6   <= n_c;
            r_neg6 <= r_neg5;
            r_dg6  <= r_dg5;

            r_c7   <= r_c6;
            r_neg7 <= r_neg6;
            r_dg7  <= r_dg6;

            r_rt[0] <= n_rt0;
            for (int k = 0; k < SqrtSteps; k++) r_rt[k+1] <= tfn_pkg::sqrt_step(r_rt[k]);

            r_dv[0] <= n_dv0;
            for (int k = 0; k < DivSteps; k++)
                r_dv[k+1] <= tfn_pkg::div_step(r_dv[k], DivSteps - 1 - k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_slot <= '0;
        end else if (load) begin
            r_ov   <= 1'b1;
            r_slot <= '0;
        end else if (r_ov && i_ready) begin
            if (r_slot == tfn_pkg::SlotLast) begin
                r_ov <= 1'b0;
            end else begin
                r_slot <= r_slot + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_nx <= n_out[0];
            r_ny <= n_out[1];
            r_nz <= n_out[2];
            r_dg <= r_dv[DivSteps].degen;
        end
    end

    assign o_valid       = r_ov;
    assign o_normal_x    = r_nx;
    assign o_normal_y    = r_ny;
    assign o_normal_z    = r_nz;
    assign o_vertex_slot = r_slot;
    assign o_last        = (r_slot == tfn_pkg::SlotLast);
    assign o_degenerate  = r_dg;

endmodule
